// ===== hdl/pidc_pkg.sv =====
package pidc_pkg;

    // field widths
    localparam int DATA_W        = 32;
    localparam int STEP_W        = 31;
    localparam int ADDR_W        = 5;
    localparam int DIFF_W        = DATA_W + 1;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // register map, word index
    typedef enum logic [2:0] {
        REG_KP       = 3'd0,
        REG_KI       = 3'd1,
        REG_KD       = 3'd2,
        REG_DRIVE_LO = 3'd3,
        REG_DRIVE_HI = 3'd4,
        REG_ACC_LO   = 3'd5,
        REG_ACC_HI   = 3'd6
    } reg_idx_t;

    // saturate a sign-extended value to the data width
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > PROD_W'(SMAX)) begin
            r = SMAX;
        end else if (v < PROD_W'(SMIN)) begin
            r = SMIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // below floor gives floor, above ceiling gives ceiling
    function automatic logic signed [DATA_W-1:0] window(
        input logic signed [DATA_W-1:0] v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [DATA_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/pidc_mul.sv =====
module pidc_mul #(
    parameter int A_W = pidc_pkg::DATA_W,
    parameter int B_W = pidc_pkg::DATA_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [A_W-1:0]      op_a,
    input  logic signed [B_W-1:0]      op_b,
    output logic                       busy,
    output logic signed [A_W+B_W-1:0]  product
);

    localparam int CNT_W = $clog2(B_W);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [A_W-1:0] a_reg, a_next;
    logic signed [A_W:0]  hi_reg, hi_next;
    logic [B_W-1:0]       lo_reg, lo_next;

    logic                 bit_last;
    logic signed [A_W+1:0] ext_a;
    logic signed [A_W+1:0] addend;
    logic signed [A_W+1:0] sum;

    // one multiplier bit per cycle, lsb first; the sign bit weighs negative
    always_comb begin
        bit_last = (cnt_reg == CNT_W'(B_W - 1));
        ext_a    = {{2{a_reg[A_W-1]}}, a_reg};
        if (lo_reg[0]) begin
            addend = bit_last ? -ext_a : ext_a;
        end else begin
            addend = '0;
        end
        sum = {hi_reg[A_W], hi_reg} + addend;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = op_a;
            hi_next   = '0;
            lo_next   = op_b;
        end else if (busy_reg) begin
            hi_next  = sum[A_W+1:1];
            lo_next  = {sum[0], lo_reg[B_W-1:1]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (bit_last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign busy    = busy_reg;
    assign product = {hi_reg[A_W-1:0], lo_reg};

endmodule

// ===== hdl/pid_controller_with_clamps.sv =====
// channel   ports                                            dir   transfer when
// -------   ----------------------------------------------   ---   -------------------------
// update    s_action s_target s_measured s_step_time         in    s_valid & s_ready
// result    m_drive                                          out   m_valid & m_ready
// config    psel penable pwrite paddr pwdata prdata pready   in    psel & penable & pwrite
//
// an update runs in two phases; the bit-serial restoring divider for the derivative
// sets the length of the first phase, and one pass of the two serial multipliers sets
// the second.
// a clear stays in idle with no result; a zero time step goes straight to the output state.
// aresetn is synchronous, active low; it empties the state and loads the register resets.
// s_ready is high only while idle; a finished result waits in the output register for
// m_ready while the next update is already taken in.
module pid_controller_with_clamps #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic signed [pidc_pkg::DATA_W-1:0] s_target,
    input  logic signed [pidc_pkg::DATA_W-1:0] s_measured,
    input  logic [pidc_pkg::STEP_W-1:0]        s_step_time,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pidc_pkg::DATA_W-1:0] m_drive,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0]        paddr,
    input  logic [pidc_pkg::DATA_W-1:0]        pwdata,
    output logic [pidc_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    import pidc_pkg::*;

    // divider numerator: full error difference with the fraction bits appended
    localparam int NUM_W  = DIFF_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(NUM_W);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_START1 = 11'b000_0000_0010,
        ST_RUN1   = 11'b000_0000_0100,
        ST_ACC1   = 11'b000_0000_1000,
        ST_ACC2   = 11'b000_0001_0000,
        ST_START2 = 11'b000_0010_0000,
        ST_RUN2   = 11'b000_0100_0000,
        ST_TERMS  = 11'b000_1000_0000,
        ST_SUM    = 11'b001_0000_0000,
        ST_WIN    = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

    // configuration registers
    logic signed [DATA_W-1:0] kp_reg, ki_reg, kd_reg;
    logic signed [DATA_W-1:0] drive_lo_reg, drive_hi_reg;
    logic signed [DATA_W-1:0] acc_lo_reg, acc_hi_reg;

    // control and controller state
    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic signed [DATA_W-1:0] last_err_reg, last_err_next;
    logic                     have_last_reg, have_last_next;
    logic                     m_valid_reg, m_valid_next;

    // per-item working registers
    logic signed [DATA_W-1:0] err_reg, err_next;
    logic [STEP_W-1:0]        dt_reg, dt_next;
    logic signed [DATA_W-1:0] tmp_reg, tmp_next;
    logic signed [DATA_W-1:0] term_p_reg, term_p_next;
    logic signed [DATA_W-1:0] term_i_reg, term_i_next;
    logic signed [DATA_W-1:0] term_d_reg, term_d_next;
    logic signed [DATA_W-1:0] deriv_reg, deriv_next;
    logic signed [DATA_W-1:0] m_drive_reg, m_drive_next;

    // serial divider
    logic                     div_busy_reg, div_busy_next;
    logic [DCNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic [NUM_W-1:0]         div_num_reg, div_num_next;
    logic [STEP_W-1:0]        div_rem_reg, div_rem_next;
    logic                     div_neg_reg, div_neg_next;

    // multiplier hookup
    logic                     mul_start;
    logic signed [DATA_W-1:0] mul0_a, mul0_b, mul1_a, mul1_b;
    logic                     mul0_busy, mul1_busy;
    logic signed [PROD_W-1:0] mul0_prod, mul1_prod;

    // datapath intermediates
    logic signed [DIFF_W-1:0] err_diff;
    logic signed [DATA_W-1:0] err_in;
    logic signed [PROD_W-1:0] shift0, shift1;
    logic signed [DIFF_W-1:0] acc_sum;
    logic signed [DIFF_W:0]   sum3;
    logic signed [DIFF_W-1:0] div_diff;
    logic [DIFF_W-1:0]        div_mag;
    logic [DATA_W-1:0]        rem_sh;
    logic                     rem_ge;
    logic                     quot_ovf_pos, quot_ovf_neg;
    logic signed [DATA_W-1:0] quot_sat;
    logic                     cfg_write;

    // ---------------------------------------------------------------
    // configuration port, zero wait states
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            drive_lo_reg <= SMIN;
            drive_hi_reg <= SMAX;
            acc_lo_reg   <= SMIN;
            acc_hi_reg   <= SMAX;
        end else if (cfg_write) begin
            // writes beyond the register list fall through and are dropped
            unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
                REG_KP:       kp_reg       <= pwdata;
                REG_KI:       ki_reg       <= pwdata;
                REG_KD:       kd_reg       <= pwdata;
                REG_DRIVE_LO: drive_lo_reg <= pwdata;
                REG_DRIVE_HI: drive_hi_reg <= pwdata;
                REG_ACC_LO:   acc_lo_reg   <= pwdata;
                REG_ACC_HI:   acc_hi_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_KP:       prdata = kp_reg;
            REG_KI:       prdata = ki_reg;
            REG_KD:       prdata = kd_reg;
            REG_DRIVE_LO: prdata = drive_lo_reg;
            REG_DRIVE_HI: prdata = drive_hi_reg;
            REG_ACC_LO:   prdata = acc_lo_reg;
            REG_ACC_HI:   prdata = acc_hi_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // two serial multipliers, shared by both phases
    // phase one: error * dt and kp * error
    // phase two: ki * accumulator and kd * derivative
    // ---------------------------------------------------------------
    assign mul_start = (state_reg == ST_START1) || (state_reg == ST_START2);

    always_comb begin
        if (state_reg == ST_START1) begin
            mul0_a = err_reg;
            mul0_b = {1'b0, dt_reg};
            mul1_a = kp_reg;
            mul1_b = err_reg;
        end else begin
            mul0_a = ki_reg;
            mul0_b = acc_reg;
            mul1_a = kd_reg;
            mul1_b = deriv_reg;
        end
    end

    pidc_mul #(
        .A_W (DATA_W),
        .B_W (DATA_W)
    ) u_mul0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul0_a),
        .op_b    (mul0_b),
        .busy    (mul0_busy),
        .product (mul0_prod)
    );

    pidc_mul #(
        .A_W (DATA_W),
        .B_W (DATA_W)
    ) u_mul1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul1_a),
        .op_b    (mul1_b),
        .busy    (mul1_busy),
        .product (mul1_prod)
    );

    // ---------------------------------------------------------------
    // datapath pieces
    // ---------------------------------------------------------------
    always_comb begin
        // error at the input, saturated
        err_diff = {s_target[DATA_W-1], s_target} - {s_measured[DATA_W-1], s_measured};
        err_in   = sat_data(PROD_W'(err_diff));

        // fixed-point rescale of the products, arithmetic shift floors
        shift0 = mul0_prod >>> FRAC_BITS;
        shift1 = mul1_prod >>> FRAC_BITS;

        // accumulator plus the saturated increment
        acc_sum = {acc_reg[DATA_W-1], acc_reg} + {tmp_reg[DATA_W-1], tmp_reg};

        // exact sum of the three gain terms
        sum3 = {{2{term_p_reg[DATA_W-1]}}, term_p_reg}
             + {{2{term_i_reg[DATA_W-1]}}, term_i_reg}
             + {{2{term_d_reg[DATA_W-1]}}, term_d_reg};

        // divider operand: magnitude of the error change
        div_diff = {err_reg[DATA_W-1], err_reg} - {last_err_reg[DATA_W-1], last_err_reg};
        div_mag  = div_diff[DIFF_W-1] ? (~div_diff + DIFF_W'(1)) : div_diff;

        // one restoring step: bring in the next numerator bit, subtract dt if it fits
        rem_sh = {div_rem_reg, div_num_reg[NUM_W-1]};
        rem_ge = (rem_sh >= {1'b0, dt_reg});

        // quotient back to signed, truncated toward zero, saturated
        quot_ovf_pos = |div_num_reg[NUM_W-1:DATA_W-1];
        quot_ovf_neg = (|div_num_reg[NUM_W-1:DATA_W])
                    || (div_num_reg[DATA_W-1] && (|div_num_reg[DATA_W-2:0]));
        if (div_neg_reg) begin
            quot_sat = quot_ovf_neg ? SMIN : -signed'(div_num_reg[DATA_W-1:0]);
        end else begin
            quot_sat = quot_ovf_pos ? SMAX : signed'(div_num_reg[DATA_W-1:0]);
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        last_err_next  = last_err_reg;
        have_last_next = have_last_reg;
        m_valid_next   = m_valid_reg;
        err_next       = err_reg;
        dt_next        = dt_reg;
        tmp_next       = tmp_reg;
        term_p_next    = term_p_reg;
        term_i_next    = term_i_reg;
        term_d_next    = term_d_reg;
        deriv_next     = deriv_reg;
        m_drive_next   = m_drive_reg;
        div_busy_next  = div_busy_reg;
        div_cnt_next   = div_cnt_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        div_neg_next   = div_neg_reg;

        // result leaves the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // divider runs on its own once started, quotient bits shift in at the bottom
        if (div_busy_reg) begin
            div_rem_next = rem_ge ? STEP_W'(rem_sh - {1'b0, dt_reg}) : rem_sh[STEP_W-1:0];
            div_num_next = {div_num_reg[NUM_W-2:0], rem_ge};
            div_cnt_next = div_cnt_reg + DCNT_W'(1);
            if (div_cnt_reg == DCNT_W'(NUM_W - 1)) begin
                div_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action) begin
                        // clear: state back to reset, no result
                        acc_next       = '0;
                        last_err_next  = '0;
                        have_last_next = 1'b0;
                    end else if (s_step_time == '0) begin
                        // invalid time step: drive zero, state untouched
                        tmp_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        err_next   = err_in;
                        dt_next    = s_step_time;
                        state_next = ST_START1;
                    end
                end
            end
            ST_START1: begin
                div_busy_next = 1'b1;
                div_cnt_next  = '0;
                div_num_next  = {div_mag, {FRAC_BITS{1'b0}}};
                div_rem_next  = '0;
                div_neg_next  = div_diff[DIFF_W-1];
                state_next    = ST_RUN1;
            end
            ST_RUN1: begin
                if (!mul0_busy && !mul1_busy && !div_busy_reg) begin
                    // increment parked in tmp for the accumulator add
                    tmp_next    = sat_data(shift0);
                    term_p_next = sat_data(shift1);
                    deriv_next  = have_last_reg ? quot_sat : '0;
                    state_next  = ST_ACC1;
                end
            end
            ST_ACC1: begin
                tmp_next       = sat_data(PROD_W'(acc_sum));
                last_err_next  = err_reg;
                have_last_next = 1'b1;
                state_next     = ST_ACC2;
            end
            ST_ACC2: begin
                // anti-windup clamp
                acc_next   = window(tmp_reg, acc_lo_reg, acc_hi_reg);
                state_next = ST_START2;
            end
            ST_START2: begin
                state_next = ST_RUN2;
            end
            ST_RUN2: begin
                if (!mul0_busy && !mul1_busy) begin
                    state_next = ST_TERMS;
                end
            end
            ST_TERMS: begin
                term_i_next = sat_data(shift0);
                term_d_next = sat_data(shift1);
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                tmp_next   = sat_data(PROD_W'(sum3));
                state_next = ST_WIN;
            end
            ST_WIN: begin
                tmp_next   = window(tmp_reg, drive_lo_reg, drive_hi_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_drive_next = tmp_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            last_err_reg  <= '0;
            have_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            last_err_reg  <= last_err_next;
            have_last_reg <= have_last_next;
            m_valid_reg   <= m_valid_next;
            div_busy_reg  <= div_busy_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg     <= err_next;
        dt_reg      <= dt_next;
        tmp_reg     <= tmp_next;
        term_p_reg  <= term_p_next;
        term_i_reg  <= term_i_next;
        term_d_reg  <= term_d_next;
        deriv_reg   <= deriv_next;
        m_drive_reg <= m_drive_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_neg_reg <= div_neg_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_drive = m_drive_reg;

endmodule
